// File: hdl/apfp_pkg.sv
// Package with the shared types and constants of the ASCII parameter frame parser.
package apfp_pkg;

  // Character codes that steer the parser.
  localparam logic [7:0] CH_END    = 8'd69;  // 'E'
  localparam logic [7:0] CH_SPEED  = 8'd88;  // 'X'
  localparam logic [7:0] CH_GAIN   = 8'd89;  // 'Y'
  localparam logic [7:0] CH_TARGET = 8'd90;  // 'Z'
  localparam logic [7:0] CH_ZERO   = 8'd48;  // '0'

  // Digit store lengths, in slots.
  localparam int SPEED_LEN  = 16;
  localparam int GAIN_LEN   = 25;
  localparam int TARGET_LEN = 11;

  localparam int SLOT_W       = 5;
  localparam int SPEED_IDX_W  = $clog2(SPEED_LEN);
  localparam int GAIN_IDX_W   = $clog2(GAIN_LEN);
  localparam int TARGET_IDX_W = $clog2(TARGET_LEN);

  localparam int NUM_VALUES = 6;
  localparam int VALUE_W    = 16;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SPEED  = 2'd1,
    MODE_GAIN   = 2'd2,
    MODE_TARGET = 2'd3
  } mode_t;

  typedef logic [SPEED_LEN-1:0][7:0]  speed_mem_t;
  typedef logic [GAIN_LEN-1:0][7:0]   gain_mem_t;
  typedef logic [TARGET_LEN-1:0][7:0] target_mem_t;

  typedef struct packed {
    logic [1:0]                          kind;
    logic [NUM_VALUES-1:0][VALUE_W-1:0]  value;
    logic                                bad;
  } result_t;

endpackage

// File: hdl/ascii_parameter_frame_parser_core.sv
// Top level of the ASCII parameter frame parser: input register, state, decode, result register.
// The parser takes one received byte per beat and can take a new beat every clock cycle
// unless a waiting result holds it back. A beat is first held in an input register; from
// there it updates the frame state and digit stores, and a closing 'E' loads the decoded
// result into the output register, where it waits until taken. 'X', 'Y' and 'Z' open speed,
// gain and target frames, every byte of an open frame (the header included, in slot 0) is
// stored as its value minus 48, and bytes past a store's end are dropped. Digits left over
// from earlier frames stay in the stores and take part in later decodes; reset clears all of
// them. The only thing that holds the input back is a waiting result that has not been
// taken while a further 'E' needs the output register; a result that waits never blocks
// ordinary bytes.
module ascii_parameter_frame_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_frame_kind,
  output logic [15:0] out_value0,
  output logic [15:0] out_value1,
  output logic [15:0] out_value2,
  output logic [15:0] out_value3,
  output logic [15:0] out_value4,
  output logic [15:0] out_value5,
  output logic        out_bad_digit
);
  import apfp_pkg::*;

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        out_vld_r, out_vld_nxt;
  result_t     result_r, decoded;
  mode_t       mode;
  speed_mem_t  speed;
  gain_mem_t   gain;
  target_mem_t target;
  logic        close_frame;
  logic        out_free;
  logic        advance;

  // An 'E' inside an open frame produces a result beat.
  assign close_frame = (in_byte_r == CH_END) && (mode != MODE_IDLE);
  assign out_free    = !out_vld_r || out_ready;
  assign advance     = in_vld_r && (!close_frame || out_free);
  assign in_ready    = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  apfp_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .mode    (mode),
    .speed   (speed),
    .gain    (gain),
    .target  (target)
  );

  // The closing 'E' is never stored, so the stores read now are what it decodes.
  apfp_decode u_decode (
    .mode   (mode),
    .speed  (speed),
    .gain   (gain),
    .target (target),
    .result (decoded)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance && close_frame) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && close_frame) begin
      result_r <= decoded;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_frame_kind = result_r.kind;
  assign out_value0     = result_r.value[0];
  assign out_value1     = result_r.value[1];
  assign out_value2     = result_r.value[2];
  assign out_value3     = result_r.value[3];
  assign out_value4     = result_r.value[4];
  assign out_value5     = result_r.value[5];
  assign out_bad_digit  = result_r.bad;

endmodule

// File: hdl/apfp_store.sv
// Frame mode, slot index and the three digit stores, updated once per beat.
module apfp_store (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output apfp_pkg::mode_t     mode,
  output apfp_pkg::speed_mem_t  speed,
  output apfp_pkg::gain_mem_t   gain,
  output apfp_pkg::target_mem_t target
);
  import apfp_pkg::*;

  mode_t              mode_r, mode_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt, slot_base;
  speed_mem_t         speed_r, speed_nxt;
  gain_mem_t          gain_r, gain_nxt;
  target_mem_t        target_r, target_nxt;
  logic [7:0]         digit;

  assign digit = rx_byte - CH_ZERO;

  // Next mode; a header also restarts the slot index.
  always_comb begin
    mode_nxt  = mode_r;
    slot_base = slot_r;
    if (step) begin
      priority if (rx_byte == CH_END) begin
        mode_nxt = MODE_IDLE;
      end else if (rx_byte == CH_SPEED) begin
        mode_nxt  = MODE_SPEED;
        slot_base = '0;
      end else if (rx_byte == CH_GAIN) begin
        mode_nxt  = MODE_GAIN;
        slot_base = '0;
      end else if (rx_byte == CH_TARGET) begin
        mode_nxt  = MODE_TARGET;
        slot_base = '0;
      end else begin
        // Any other byte leaves the mode and the index as they are.
      end
    end
  end

  // Store the byte into the open frame's store while there is room.
  always_comb begin
    slot_nxt   = slot_base;
    speed_nxt  = speed_r;
    gain_nxt   = gain_r;
    target_nxt = target_r;
    if (step) begin
      unique case (mode_nxt)
        MODE_SPEED: begin
          if (slot_base < SLOT_W'(SPEED_LEN)) begin
            speed_nxt[slot_base[SPEED_IDX_W-1:0]] = digit;
            slot_nxt = slot_base + SLOT_W'(1);
          end
        end
        MODE_GAIN: begin
          if (slot_base < SLOT_W'(GAIN_LEN)) begin
            gain_nxt[slot_base[GAIN_IDX_W-1:0]] = digit;
            slot_nxt = slot_base + SLOT_W'(1);
          end
        end
        MODE_TARGET: begin
          if (slot_base < SLOT_W'(TARGET_LEN)) begin
            target_nxt[slot_base[TARGET_IDX_W-1:0]] = digit;
            slot_nxt = slot_base + SLOT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      slot_r   <= '0;
      speed_r  <= '0;
      gain_r   <= '0;
      target_r <= '0;
    end else begin
      mode_r   <= mode_nxt;
      slot_r   <= slot_nxt;
      speed_r  <= speed_nxt;
      gain_r   <= gain_nxt;
      target_r <= target_nxt;
    end
  end

  assign mode   = mode_r;
  assign speed  = speed_r;
  assign gain   = gain_r;
  assign target = target_r;

endmodule

// File: hdl/apfp_decode.sv
// Combinational decode of the open frame's digit store into one result.
module apfp_decode (
  input  apfp_pkg::mode_t       mode,
  input  apfp_pkg::speed_mem_t  speed,
  input  apfp_pkg::gain_mem_t   gain,
  input  apfp_pkg::target_mem_t target,
  output apfp_pkg::result_t     result
);
  import apfp_pkg::*;

  function automatic logic [19:0] dec2(input logic [7:0] hi, input logic [7:0] lo);
    dec2 = {12'd0, hi} * 20'd10 + {12'd0, lo};
  endfunction

  function automatic logic [19:0] dec3(input logic [7:0] d2, input logic [7:0] d1,
                                       input logic [7:0] d0);
    dec3 = {12'd0, d2} * 20'd100 + {12'd0, d1} * 20'd10 + {12'd0, d0};
  endfunction

  logic [NUM_VALUES-1:0][19:0] spd_v, gain_v, tgt_v;
  logic spd_bad, gain_bad, tgt_bad;

  always_comb begin
    spd_v   = '0;
    gain_v  = '0;
    tgt_v   = '0;
    spd_bad = 1'b0;
    gain_bad = 1'b0;
    tgt_bad = 1'b0;
    for (int k = 0; k < 5; k++) begin
      spd_v[k] = dec3(speed[3*k+1], speed[3*k+2], speed[3*k+3]);
      tgt_v[k] = dec2(target[2*k+1], target[2*k+2]);
    end
    for (int k = 0; k < NUM_VALUES; k++) begin
      gain_v[k] = dec2(gain[4*k+1], gain[4*k+2]) * 20'd100
                + dec2(gain[4*k+3], gain[4*k+4]);
    end
    // The header sits in slot 0 and never counts as a digit.
    for (int i = 1; i < SPEED_LEN; i++)  spd_bad  = spd_bad  | (speed[i]  > 8'd9);
    for (int i = 1; i < GAIN_LEN; i++)   gain_bad = gain_bad | (gain[i]   > 8'd9);
    for (int i = 1; i < TARGET_LEN; i++) tgt_bad  = tgt_bad  | (target[i] > 8'd9);
  end

  always_comb begin
    result.kind = 2'(mode) - 2'd1;
    result.value = '0;
    unique case (mode)
      MODE_SPEED: begin
        for (int k = 0; k < NUM_VALUES; k++) result.value[k] = spd_v[k][VALUE_W-1:0];
        result.bad = spd_bad;
      end
      MODE_GAIN: begin
        for (int k = 0; k < NUM_VALUES; k++) result.value[k] = gain_v[k][VALUE_W-1:0];
        result.bad = gain_bad;
      end
      MODE_TARGET, MODE_IDLE: begin
        for (int k = 0; k < NUM_VALUES; k++) result.value[k] = tgt_v[k][VALUE_W-1:0];
        result.bad = tgt_bad;
      end
    endcase
  end

endmodule

// File: hdl/apfp_checker.sv
// Port-level assertions for the parser top level, with the bind that attaches them.
module apfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_frame_kind,
  input logic [15:0] out_value0,
  input logic [15:0] out_value1,
  input logic [15:0] out_value2,
  input logic [15:0] out_value3,
  input logic [15:0] out_value4,
  input logic [15:0] out_value5,
  input logic        out_bad_digit
);
  import apfp_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_kind)
      && $stable(out_value0) && $stable(out_value1) && $stable(out_value2)
      && $stable(out_value3) && $stable(out_value4) && $stable(out_value5)
      && $stable(out_bad_digit))
    else $error("result beat changed while stalled");

  // Only three frame kinds exist.
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_kind != 2'd3)
    else $error("result beat with an unknown frame kind");

  // Only gain frames carry a sixth value.
  a_value5_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_kind != 2'd1 |-> out_value5 == 16'd0)
    else $error("sixth value set outside a gain frame");

  // A fresh result traces back to an accepted 'E', held first in the input register and then in the output register.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_rx_byte == CH_END, 2))
    else $error("result beat without a closing byte");

endmodule

bind ascii_parameter_frame_parser_core apfp_checker u_apfp_checker (.*);
